@@ sv/fht_pkg.sv @@
// ----------------------------------------------------------------------------
// fht_pkg
// Shared constants for the flow hash table.
// ----------------------------------------------------------------------------
package fht_pkg;

	localparam int HASH_BITS_DEF = 8;
	localparam int MAX_FLOWS_DEF = 1024;

	localparam int KEY_WORDS = 5;
	localparam int KEY_BITS  = KEY_WORDS * 64;
	localparam int HND_W     = 10;
	localparam int BKT_W     = 8;
	localparam int CNT_W     = 11;

	localparam logic [31:0] GOLDEN = 32'h9E3779B9;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_MISS  = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;
	localparam logic [1:0] STS_BADH  = 2'd3;

endpackage

@@ sv/fht_hash.sv @@
// ----------------------------------------------------------------------------
// fht_hash
// Two-stage bucket hash: xor fold of the 32-bit key chunks, then golden-ratio multiply.
// ----------------------------------------------------------------------------
module fht_hash #(
	parameter int HASH_BITS = fht_pkg::HASH_BITS_DEF
) (
	input  logic                        clk,
	input  logic [fht_pkg::KEY_BITS-1:0] key,
	output logic [HASH_BITS-1:0]        bkt
);

	localparam int CHUNKS = fht_pkg::KEY_BITS / 32;

	logic [31:0] fold;
	logic [31:0] h_s1;
	logic [31:0] prod;

	// no byte rotation: a plain xor of the 32-bit chunks of the key
	always_comb begin
		fold = '0;
		for (int c = 0; c < CHUNKS; c++) begin
			fold = fold ^ key[c*32 +: 32];
		end
	end

	assign prod = h_s1 * fht_pkg::GOLDEN;

	always_ff @(posedge clk) begin
		h_s1 <= fold;
		bkt  <= prod[31 -: HASH_BITS];
	end

endmodule

@@ sv/flow_hash_table.sv @@
// ----------------------------------------------------------------------------
// flow_hash_table
// Chained hash table of flows in on-chip memories: add, lookup, remove.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       sink       in_valid/in_ready    func, key_word_0..4, server_index,
//                                          entry_handle
// out      source     out_valid/out_ready  status, found, result_handle,
//                                          bucket, flow_count
//
// One word at a time: the next word is taken only once back in idle. The key
// is hashed first; then add pops a recycled handle or takes a fresh one,
// reads the bucket tail and links the entry (straight to finish when full),
// lookup walks the bucket chain, remove walks it up to and including the
// handle. Each chain step is one read of the entry memories plus a compare.
// After reset a clearing pass over max(MAX_FLOWS, 2**HASH_BITS) addresses
// runs before the first word is taken. A stalled output holds the finished
// word; the next input is taken meanwhile and waits at the end of its work.
// ----------------------------------------------------------------------------
module flow_hash_table #(
	parameter int HASH_BITS = fht_pkg::HASH_BITS_DEF,
	parameter int MAX_FLOWS = fht_pkg::MAX_FLOWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [63:0] key_word_0,
	input  logic [63:0] key_word_1,
	input  logic [63:0] key_word_2,
	input  logic [63:0] key_word_3,
	input  logic [63:0] key_word_4,
	input  logic [7:0]  server_index,
	input  logic [fht_pkg::HND_W-1:0] entry_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        found,
	output logic [fht_pkg::HND_W-1:0] result_handle,
	output logic [fht_pkg::BKT_W-1:0] bucket,
	output logic [fht_pkg::CNT_W-1:0] flow_count
);

	localparam int HW    = $clog2(MAX_FLOWS);
	localparam int LW    = HW + 1;
	localparam int CW    = HW + 1;
	localparam int NB    = 1 << HASH_BITS;
	localparam int CLR_N = (MAX_FLOWS > NB) ? MAX_FLOWS : NB;
	localparam int CLRW  = $clog2(CLR_N);
	localparam int MW    = 1 + 8 + HASH_BITS;
	localparam int KB    = fht_pkg::KEY_BITS;
	localparam logic [LW-1:0] NULL_L = '1;

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_H1   = 5'd2;
	localparam logic [4:0] S_H2   = 5'd3;
	localparam logic [4:0] S_DSP  = 5'd4;
	localparam logic [4:0] S_POP  = 5'd5;
	localparam logic [4:0] S_ATL  = 5'd6;
	localparam logic [4:0] S_AL   = 5'd7;
	localparam logic [4:0] S_LH   = 5'd8;
	localparam logic [4:0] S_LR   = 5'd9;
	localparam logic [4:0] S_LC   = 5'd10;
	localparam logic [4:0] S_RM   = 5'd11;
	localparam logic [4:0] S_RH   = 5'd12;
	localparam logic [4:0] S_RR   = 5'd13;
	localparam logic [4:0] S_RC   = 5'd14;
	localparam logic [4:0] S_FIN  = 5'd15;

	logic [4:0]          state_q;
	logic [CLRW-1:0]     clr_q;
	logic [1:0]          func_q;
	logic [KB-1:0]       key_q;
	logic [7:0]          srv_q;
	logic [fht_pkg::HND_W-1:0] hnd_q;
	logic [HASH_BITS-1:0] hbkt;
	logic [HASH_BITS-1:0] bkt_q;
	logic [LW-1:0]       e_q, prev_q, tail_q;
	logic [CW-1:0]       cnt_q, rc_q, nn_q;
	logic [1:0]          rst_q;
	logic                rfnd_q;
	logic [HW-1:0]       rh_q;
	logic [HASH_BITS-1:0] rb_q;

	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic                out_found_q;
	logic [HW-1:0]       out_rh_q;
	logic [HASH_BITS-1:0] out_bkt_q;
	logic [CW-1:0]       out_cnt_q;

	logic [KB-1:0]       key_mem [MAX_FLOWS];
	logic [MW-1:0]       meta_mem [MAX_FLOWS];
	logic [LW-1:0]       next_mem [MAX_FLOWS];
	logic [LW-1:0]       head_mem [NB];
	logic [LW-1:0]       tail_mem [NB];
	logic [HW-1:0]       stk_mem [MAX_FLOWS];

	logic [KB-1:0]       key_rd;
	logic [MW-1:0]       meta_rd;
	logic [LW-1:0]       next_rd, head_rd, tail_rd;
	logic [HW-1:0]       stk_rd;

	logic                key_we, meta_we, next_we, head_we, tail_we, stk_we;
	logic [HW-1:0]       key_wa, meta_wa, next_wa, stk_wa;
	logic [HASH_BITS-1:0] head_wa, tail_wa;
	logic [MW-1:0]       meta_wd;
	logic [LW-1:0]       next_wd, head_wd, tail_wd;
	logic [HW-1:0]       stk_wd;
	logic [HW-1:0]       ent_ra, next_ra, stk_ra;
	logic [HASH_BITS-1:0] hb_ra;

	logic                in_acc, fin_go;
	logic                meta_valid;
	logic [7:0]          meta_srv;
	logic [HASH_BITS-1:0] meta_bkt;
	logic                hnd_ok, e_is_hnd;

	fht_hash #(.HASH_BITS(HASH_BITS)) u_hash (
		.clk (clk),
		.key (key_q),
		.bkt (hbkt)
	);

	assign meta_valid = meta_rd[MW-1];
	assign meta_srv   = meta_rd[HASH_BITS +: 8];
	assign meta_bkt   = meta_rd[HASH_BITS-1:0];
	assign hnd_ok     = 32'(hnd_q) < MAX_FLOWS;
	assign e_is_hnd   = !e_q[HW] && (32'(e_q[HW-1:0]) == 32'(hnd_q));

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign fin_go   = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		key_we  = 1'b0;
		meta_we = 1'b0;
		next_we = 1'b0;
		head_we = 1'b0;
		tail_we = 1'b0;
		stk_we  = 1'b0;
		key_wa  = e_q[HW-1:0];
		meta_wa = e_q[HW-1:0];
		next_wa = e_q[HW-1:0];
		stk_wa  = rc_q[HW-1:0];
		head_wa = hbkt;
		tail_wa = hbkt;
		meta_wd = {1'b1, srv_q, hbkt};
		next_wd = NULL_L;
		head_wd = e_q;
		tail_wd = e_q;
		stk_wd  = hnd_q[HW-1:0];
		ent_ra  = e_q[HW-1:0];
		next_ra = e_q[HW-1:0];
		stk_ra  = HW'(rc_q - CW'(1));
		hb_ra   = hbkt;
		case (state_q)
			S_CLR: begin
				meta_we = 1'b1;
				meta_wa = clr_q[HW-1:0];
				meta_wd = '0;
				head_we = 1'b1;
				tail_we = 1'b1;
				head_wa = clr_q[HASH_BITS-1:0];
				tail_wa = clr_q[HASH_BITS-1:0];
				head_wd = NULL_L;
				tail_wd = NULL_L;
			end
			S_DSP: begin
				ent_ra = hnd_q[HW-1:0];
			end
			S_ATL: begin
				key_we  = 1'b1;
				meta_we = 1'b1;
				next_we = 1'b1;
				tail_we = 1'b1;
			end
			S_AL: begin
				if (tail_q[HW]) begin
					head_we = 1'b1;
				end else begin
					next_we = 1'b1;
					next_wa = tail_q[HW-1:0];
					next_wd = e_q;
				end
			end
			S_RM: begin
				hb_ra = meta_bkt;
			end
			S_RC: begin
				if (e_is_hnd) begin
					if (prev_q[HW]) begin
						head_we = 1'b1;
						head_wa = bkt_q;
						head_wd = next_rd;
					end else begin
						next_we = 1'b1;
						next_wa = prev_q[HW-1:0];
						next_wd = next_rd;
					end
					if (tail_q == e_q) begin
						tail_we = 1'b1;
						tail_wa = bkt_q;
						tail_wd = prev_q;
					end
					meta_we = 1'b1;
					meta_wa = hnd_q[HW-1:0];
					meta_wd = '0;
					stk_we  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_q;
		end
		key_rd <= key_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_wa] <= meta_wd;
		end
		meta_rd <= meta_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd <= next_mem[next_ra];
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_wa] <= head_wd;
		end
		head_rd <= head_mem[hb_ra];
	end

	always_ff @(posedge clk) begin
		if (tail_we) begin
			tail_mem[tail_wa] <= tail_wd;
		end
		tail_rd <= tail_mem[hb_ra];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		stk_rd <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func;
			key_q  <= {key_word_4, key_word_3, key_word_2, key_word_1, key_word_0};
			srv_q  <= server_index;
			hnd_q  <= entry_handle;
		end
		if (fin_go) begin
			out_status_q <= rst_q;
			out_found_q  <= rfnd_q;
			out_rh_q     <= rh_q;
			out_bkt_q    <= rb_q;
			out_cnt_q    <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cnt_q       <= '0;
			rc_q        <= '0;
			nn_q        <= '0;
			out_valid_q <= 1'b0;
			e_q         <= NULL_L;
			prev_q      <= NULL_L;
			tail_q      <= NULL_L;
			bkt_q       <= '0;
			rst_q       <= fht_pkg::STS_MISS;
			rfnd_q      <= 1'b0;
			rh_q        <= '0;
			rb_q        <= '0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CLRW'(1);
					if (clr_q == CLRW'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_H1;
					end
				end
				S_H1: state_q <= S_H2;
				S_H2: state_q <= S_DSP;
				S_DSP: begin
					rfnd_q <= 1'b0;
					rh_q   <= '0;
					case (func_q)
						fht_pkg::FUNC_ADD: begin
							rb_q <= hbkt;
							if (cnt_q == CW'(MAX_FLOWS)) begin
								rst_q   <= fht_pkg::STS_FULL;
								state_q <= S_FIN;
							end else if (rc_q != '0) begin
								rst_q   <= fht_pkg::STS_MISS;
								state_q <= S_POP;
							end else begin
								rst_q   <= fht_pkg::STS_MISS;
								e_q     <= {1'b0, nn_q[HW-1:0]};
								nn_q    <= nn_q + CW'(1);
								state_q <= S_ATL;
							end
						end
						fht_pkg::FUNC_LOOKUP: begin
							rb_q    <= hbkt;
							rst_q   <= fht_pkg::STS_MISS;
							state_q <= S_LH;
						end
						fht_pkg::FUNC_REMOVE: begin
							rb_q  <= '0;
							rst_q <= fht_pkg::STS_BADH;
							if (hnd_ok) begin
								state_q <= S_RM;
							end else begin
								state_q <= S_FIN;
							end
						end
						default: begin
							rb_q    <= '0;
							rst_q   <= fht_pkg::STS_MISS;
							state_q <= S_FIN;
						end
					endcase
				end
				S_POP: begin
					e_q     <= {1'b0, stk_rd};
					rc_q    <= rc_q - CW'(1);
					state_q <= S_ATL;
				end
				S_ATL: begin
					tail_q  <= tail_rd;
					state_q <= S_AL;
				end
				S_AL: begin
					cnt_q   <= cnt_q + CW'(1);
					rst_q   <= fht_pkg::STS_OK;
					rh_q    <= e_q[HW-1:0];
					state_q <= S_FIN;
				end
				S_LH: begin
					e_q     <= head_rd;
					state_q <= S_LR;
				end
				S_LR: begin
					if (e_q[HW]) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_LC;
					end
				end
				S_LC: begin
					if (meta_srv == srv_q && key_rd == key_q) begin
						rst_q   <= fht_pkg::STS_OK;
						rfnd_q  <= 1'b1;
						rh_q    <= e_q[HW-1:0];
						state_q <= S_FIN;
					end else begin
						e_q     <= next_rd;
						state_q <= S_LR;
					end
				end
				S_RM: begin
					bkt_q <= meta_bkt;
					if (meta_valid) begin
						state_q <= S_RH;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RH: begin
					e_q     <= head_rd;
					tail_q  <= tail_rd;
					prev_q  <= NULL_L;
					state_q <= S_RR;
				end
				S_RR: begin
					if (e_q[HW]) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RC;
					end
				end
				S_RC: begin
					if (e_is_hnd) begin
						rc_q    <= rc_q + CW'(1);
						cnt_q   <= cnt_q - CW'(1);
						rst_q   <= fht_pkg::STS_OK;
						rh_q    <= e_q[HW-1:0];
						rb_q    <= bkt_q;
						state_q <= S_FIN;
					end else begin
						prev_q  <= e_q;
						e_q     <= next_rd;
						state_q <= S_RR;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign found         = out_found_q;
	assign result_handle = fht_pkg::HND_W'(out_rh_q);
	assign bucket        = fht_pkg::BKT_W'(out_bkt_q);
	assign flow_count    = fht_pkg::CNT_W'(out_cnt_q);

	// stored + recycled + never used handles add up to the table size whenever the table is idle
	a_handles_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		((32'(cnt_q) + 32'(rc_q) + MAX_FLOWS - 32'(nn_q)) == MAX_FLOWS))
		else $error("handle accounting broken");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_FLOWS)
		else $error("flow count above table size");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result posted outside finish");

	a_tail_on_unlink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RC && e_is_hnd) |-> !tail_q[HW])
		else $error("unlinking from a bucket with no tail");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> !$past(in_acc))
		else $error("word taken while busy");

endmodule
